// ===== src/vaq_pkg.sv =====
// vaq_pkg: shared types and constants of the vertex attribute quantizer
// holds vertex/result payload structs, pipeline stage struct, register indexes
// no dependencies
`timescale 1ns / 1ps
package vaq_pkg;

	localparam int NUM_REGS = 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

	// number of iteration stages, one quotient bit each
	localparam int ITER_STAGES = 16;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
	} vtx_in_t;

	typedef struct packed {
		logic [15:0]        qpos_x;
		logic [15:0]        qpos_y;
		logic [15:0]        qpos_z;
		logic signed [15:0] qnorm_x;
		logic signed [15:0] qnorm_y;
		logic [15:0]        qtex_u;
		logic [15:0]        qtex_v;
	} vtx_out_t;

	// position axis divider state
	typedef struct packed {
		logic        zero;
		logic        sat;
		logic [32:0] rem;
		logic [32:0] ext;
		logic [15:0] nlo;
		logic [15:0] quo;
	} axis_t;

	// normal component divide-by-root state
	typedef struct packed {
		logic        neg;
		logic [61:0] a2;
		logic [61:0] acc_s;
		logic [47:0] acc_p;
		logic [15:0] quo;
	} nrm_t;

	typedef struct packed {
		logic            vld;
		axis_t [2:0]     ax;
		nrm_t  [1:0]     nm;
		logic [31:0]     len2;
		logic            nzero;
		logic [15:0]     tex_u;
		logic [15:0]     tex_v;
	} stage_t;

endpackage

// ===== src/vaq_iter_stage.sv =====
// vaq_iter_stage: one registered iteration step, one quotient bit per unit
// restoring divide for three position axes, root compare for two normal parts
// depends on vaq_pkg
`timescale 1ns / 1ps
module vaq_iter_stage #(
	parameter int BIT = 15
) (
	input  logic            clk,
	input  logic            arst_n,
	input  vaq_pkg::stage_t din,
	output vaq_pkg::stage_t dout
);
	import vaq_pkg::*;

	stage_t nxt;

	always_comb begin
		logic [33:0] r2;
		logic [33:0] sub;
		logic [65:0] cand;
		nxt = din;
		for (int i = 0; i < 3; i++) begin
			r2  = {din.ax[i].rem, din.ax[i].nlo[15]};
			sub = r2 - {1'b0, din.ax[i].ext};
			nxt.ax[i].nlo = {din.ax[i].nlo[14:0], 1'b0};
			if (r2 >= {1'b0, din.ax[i].ext}) begin
				nxt.ax[i].rem      = sub[32:0];
				nxt.ax[i].quo[BIT] = 1'b1;
			end else begin
				nxt.ax[i].rem = r2[32:0];
			end
		end
		for (int j = 0; j < 2; j++) begin
			// (q + 2^b)^2 * len2 built from running q*len2 and q^2*len2
			cand = 66'(din.nm[j].acc_s) + (66'(din.nm[j].acc_p) << (BIT + 1))
				+ (66'(din.len2) << (2 * BIT));
			if (cand <= 66'(din.nm[j].a2)) begin
				nxt.nm[j].acc_s    = cand[61:0];
				nxt.nm[j].acc_p    = din.nm[j].acc_p + (48'(din.len2) << BIT);
				nxt.nm[j].quo[BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout <= nxt;
		end
	end

endmodule

// ===== src/vertex_attribute_quantizer.sv =====
// vertex_attribute_quantizer: a start transfer passes the capture register, the setup
// register, sixteen one-bit iteration stages and the output register before its result
// strobe; throughput one vertex per cycle, busy stays low; arst_n clears box registers
// to zero and all valid bits
// results cannot be stalled by the receiver
`timescale 1ns / 1ps
module vertex_attribute_quantizer #(
	parameter int POS_FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  vaq_pkg::vtx_in_t            vtx,
	output logic                        res_valid,
	output vaq_pkg::vtx_out_t           res,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [vaq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                 cfg_data
);
	import vaq_pkg::*;

	// smallest lsb count above 0.0001
	localparam int THRESH = (1 << POS_FRAC_BITS) / 10000 + 1;

	// box registers
	logic signed [31:0] box_min_q [3];
	logic signed [31:0] box_max_q [3];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				box_min_q[i] <= '0;
				box_max_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_X: box_min_q[0] <= cfg_data;
				REG_MIN_Y: box_min_q[1] <= cfg_data;
				REG_MIN_Z: box_min_q[2] <= cfg_data;
				REG_MAX_X: box_max_q[0] <= cfg_data;
				REG_MAX_Y: box_max_q[1] <= cfg_data;
				REG_MAX_Z: box_max_q[2] <= cfg_data;
				default: ; // out of range index, write dropped
			endcase
		end
	end

	// ---------------- stage 1: differences, squares, tex clamp ----------------
	logic               vld_s1;
	logic signed [32:0] ext_s1 [3];
	logic signed [32:0] dif_s1 [3];
	logic [31:0]        sq_s1  [3];
	logic [30:0]        amag_s1 [2];
	logic               neg_s1 [2];
	logic               nzero_s1;
	logic [15:0]        tex_u_s1;
	logic [15:0]        tex_v_s1;

	logic signed [31:0] pos_in [3];
	logic signed [15:0] nrm_in [3];

	assign pos_in = '{vtx.pos_x, vtx.pos_y, vtx.pos_z};
	assign nrm_in = '{vtx.norm_x, vtx.norm_y, vtx.norm_z};

	// clamp to 0..1 then scale by 65535/65536, which is c-1 for c above zero
	function automatic logic [15:0] tex_quant(input logic signed [31:0] t);
		logic [15:0] r;
		if (t <= 0)
			r = '0;
		else if (t >= 32'sd65536)
			r = 16'hFFFF;
		else
			r = 16'(t - 32'sd1);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		logic [15:0] mag;
		for (int i = 0; i < 3; i++) begin
			ext_s1[i] <= 33'(box_max_q[i]) - 33'(box_min_q[i]);
			dif_s1[i] <= 33'(pos_in[i]) - 33'(box_min_q[i]);
			sq_s1[i]  <= 32'(nrm_in[i] * nrm_in[i]);
		end
		for (int j = 0; j < 2; j++) begin
			mag = nrm_in[j][15] ? 16'(-nrm_in[j]) : nrm_in[j];
			// mag * 32767 by shift and subtract
			amag_s1[j] <= {mag, 15'b0} - 31'(mag);
			neg_s1[j]  <= nrm_in[j][15];
		end
		nzero_s1 <= (vtx.norm_x == '0) && (vtx.norm_y == '0) && (vtx.norm_z == '0);
		tex_u_s1 <= tex_quant(vtx.tex_u);
		tex_v_s1 <= tex_quant(vtx.tex_v);
	end

	// ---------------- stage 2: flags, numerators, len2, a^2 ----------------
	stage_t stg [ITER_STAGES+1];
	stage_t setup_nxt;

	always_comb begin
		logic [48:0] num;
		setup_nxt       = '0;
		setup_nxt.vld   = vld_s1;
		for (int i = 0; i < 3; i++) begin
			num = {dif_s1[i][32:0], 16'b0} - 49'(dif_s1[i][32:0]);
			setup_nxt.ax[i].zero = (ext_s1[i] < 33'(THRESH)) || (dif_s1[i] <= 0);
			setup_nxt.ax[i].sat  = dif_s1[i] >= ext_s1[i];
			setup_nxt.ax[i].ext  = ext_s1[i];
			setup_nxt.ax[i].rem  = num[48:16];
			setup_nxt.ax[i].nlo  = num[15:0];
		end
		for (int j = 0; j < 2; j++) begin
			setup_nxt.nm[j].neg = neg_s1[j];
			setup_nxt.nm[j].a2  = 62'(amag_s1[j]) * 62'(amag_s1[j]);
		end
		setup_nxt.len2  = sq_s1[0] + sq_s1[1] + sq_s1[2];
		setup_nxt.nzero = nzero_s1;
		setup_nxt.tex_u = tex_u_s1;
		setup_nxt.tex_v = tex_v_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg[0] <= '0;
		end else begin
			stg[0] <= setup_nxt;
		end
	end

	// ---------------- iteration stages, msb first ----------------
	for (genvar k = 0; k < ITER_STAGES; k++) begin : g_iter
		vaq_iter_stage #(.BIT(ITER_STAGES - 1 - k)) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (stg[k]),
			.dout   (stg[k+1])
		);
	end

	// ---------------- output register ----------------
	stage_t   fin;
	vtx_out_t out_nxt;
	logic     vld_q;
	vtx_out_t res_q;

	assign fin = stg[ITER_STAGES];

	function automatic logic [15:0] pos_sel(input axis_t a);
		logic [15:0] r;
		if (a.zero)
			r = '0;
		else if (a.sat)
			r = 16'hFFFF;
		else
			r = a.quo;
		return r;
	endfunction

	function automatic logic [15:0] nrm_sel(input nrm_t n, input logic nz);
		logic [15:0] r;
		if (nz)
			r = '0;
		else if (n.neg)
			r = 16'(-n.quo);
		else
			r = n.quo;
		return r;
	endfunction

	always_comb begin
		out_nxt.qpos_x  = pos_sel(fin.ax[0]);
		out_nxt.qpos_y  = pos_sel(fin.ax[1]);
		out_nxt.qpos_z  = pos_sel(fin.ax[2]);
		out_nxt.qnorm_x = nrm_sel(fin.nm[0], fin.nzero);
		out_nxt.qnorm_y = nrm_sel(fin.nm[1], fin.nzero);
		out_nxt.qtex_u  = fin.tex_u;
		out_nxt.qtex_v  = fin.tex_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= fin.vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= out_nxt;
	end

	assign res_valid = vld_q;
	assign res       = res_q;

endmodule

// ===== src/vaq_checker.sv =====
// vaq_checker: port-level timing and value checks of the quantizer
// bound to vertex_attribute_quantizer; depends on vaq_pkg
`timescale 1ns / 1ps
module vaq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input vaq_pkg::vtx_in_t  vtx,
	input logic              res_valid,
	input vaq_pkg::vtx_out_t res
);
	import vaq_pkg::*;

	// every transfer yields a strobe after the fixed latency
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##19 res_valid)
		else $error("missing result strobe");

	// no strobe without a transfer
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(start && !busy, 19))
		else $error("result strobe without transfer");

	// zero-length normal gives zero components
	a_nzero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && vtx.norm_x == '0 && vtx.norm_y == '0 && vtx.norm_z == '0)
		|-> ##19 (res.qnorm_x == '0 && res.qnorm_y == '0))
		else $error("zero normal not zero");

	// negative u clamps to zero
	a_tex: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && vtx.tex_u[31]) |-> ##19 (res.qtex_u == '0))
		else $error("negative u not clamped");

endmodule

bind vertex_attribute_quantizer vaq_checker u_vaq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.vtx       (vtx),
	.res_valid (res_valid),
	.res       (res)
);

// ===== tb/testbench.sv =====
// testbench: self-checking bench for the vertex attribute quantizer
// drives vertices and box register writes, predicts each packed vertex, checks strobed results
// depends on vaq_pkg and vertex_attribute_quantizer
`timescale 1ns / 1ps

class vtx_scoreboard;
	vaq_pkg::vtx_out_t pending[$];
	int unsigned mismatches;
	int unsigned stray;

	function void note_vertex(vaq_pkg::vtx_out_t want);
		pending.push_back(want);
	endfunction

	function void check_result(vaq_pkg::vtx_out_t got);
		vaq_pkg::vtx_out_t want;
		if (pending.size() == 0) begin
			stray++;
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %h", got);
			return;
		end
		want = pending.pop_front();
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected %h actual %h", want, got);
		end
	endfunction
endclass

module testbench;
	import vaq_pkg::*;

	localparam int LATENCY = 19;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	vtx_in_t vtx = '0;
	logic res_valid;
	vtx_out_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// local copy of the box registers
	logic signed [31:0] box_lo[3];
	logic signed [31:0] box_hi[3];

	vtx_scoreboard sb;
	longint cycles = 0;
	bit calm = 0;

	vertex_attribute_quantizer dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .vtx(vtx),
		.res_valid(res_valid), .res(res), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// position axis: scale offset into box to 0..65535
	function automatic logic [15:0] axis_code(logic signed [31:0] p,
			logic signed [31:0] lo, logic signed [31:0] hi);
		longint span, off;
		span = longint'(hi) - longint'(lo);
		off = longint'(p) - longint'(lo);
		// threshold is the smallest lsb count above 0.0001
		if (span < longint'((64'd1 << 16) / 10000 + 1)) return 16'd0;
		if (off <= 0) return 16'd0;
		if (off >= span) return 16'hffff;
		return 16'((off * 65535) / span);
	endfunction

	// truncated c*32767/|n| by bitwise search on squares
	function automatic logic [15:0] norm_code(longint c, longint len2);
		longint unsigned mag, num2, q, t;
		mag = (c < 0) ? -c : c;
		num2 = (mag * 32767) * (mag * 32767);
		q = 0;
		for (int b = 14; b >= 0; b--) begin
			t = q | (64'd1 << b);
			if (t * t * longint'(len2) <= num2) q = t;
		end
		if (c < 0) q = -q;
		return q[15:0];
	endfunction

	function automatic logic [15:0] uv_code(logic signed [31:0] t);
		longint c;
		c = t;
		if (c < 0) c = 0;
		if (c > 65536) c = 65536;
		return 16'((c * 65535) >> 16);
	endfunction

	function automatic vtx_out_t pack_vertex(vtx_in_t v);
		vtx_out_t o;
		longint nx, ny, nz, len2;
		nx = v.norm_x;
		ny = v.norm_y;
		nz = v.norm_z;
		len2 = nx * nx + ny * ny + nz * nz;
		o.qpos_x = axis_code(v.pos_x, box_lo[0], box_hi[0]);
		o.qpos_y = axis_code(v.pos_y, box_lo[1], box_hi[1]);
		o.qpos_z = axis_code(v.pos_z, box_lo[2], box_hi[2]);
		// zero-length normal gives zero
		o.qnorm_x = (len2 == 0) ? 16'd0 : norm_code(nx, len2);
		o.qnorm_y = (len2 == 0) ? 16'd0 : norm_code(ny, len2);
		o.qtex_u = uv_code(v.tex_u);
		o.qtex_v = uv_code(v.tex_v);
		return o;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 14);
	endfunction

	// one register write transfer, also mirrored into the local box
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MIN_X: box_lo[0] = val;
			REG_MIN_Y: box_lo[1] = val;
			REG_MIN_Z: box_lo[2] = val;
			REG_MAX_X: box_hi[0] = val;
			REG_MAX_Y: box_hi[1] = val;
			REG_MAX_Z: box_hi[2] = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
			logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
		write_reg(REG_MIN_X, lx);
		write_reg(REG_MIN_Y, ly);
		write_reg(REG_MIN_Z, lz);
		write_reg(REG_MAX_X, hx);
		write_reg(REG_MAX_Y, hy);
		write_reg(REG_MAX_Z, hz);
		cfg_valid <= 1'b0;
	endtask

	// send one vertex; start stays high across back-to-back transfers
	task automatic send_vertex(vtx_in_t v);
		while (idle_now()) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		vtx <= v;
		do @(posedge clk); while (busy);
		sb.note_vertex(pack_vertex(v));
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_word(logic signed [31:0] lo, logic signed [31:0] hi);
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			3: return lo;
			4: return hi;
			5: return lo - $urandom_range(3);
			6: return hi + $urandom_range(3);
			default: return lo + (($urandom() % 64'(longint'(hi) - longint'(lo) + 1)));
		endcase
	endfunction

	function automatic logic [31:0] pick_uv();
		case ($urandom_range(5))
			0: return $urandom();
			1: return 32'h0001_0000 + $urandom_range(2) - 1;
			2: return $urandom_range(3);
			default: return $urandom_range(32'h0001_0000);
		endcase
	endfunction

	function automatic logic [15:0] pick_norm();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h0000;
			2: return $urandom_range(4) - 2;
			default: return $urandom();
		endcase
	endfunction

	function automatic vtx_in_t random_vertex();
		vtx_in_t v;
		v.pos_x = pick_word(box_lo[0], box_hi[0]);
		v.pos_y = pick_word(box_lo[1], box_hi[1]);
		v.pos_z = pick_word(box_lo[2], box_hi[2]);
		v.norm_x = pick_norm();
		v.norm_y = pick_norm();
		v.norm_z = pick_norm();
		v.tex_u = pick_uv();
		v.tex_v = pick_uv();
		return v;
	endfunction

	// result monitor: strobe lasts one cycle, no back-pressure
	always @(posedge clk) begin
		if (arst_n && res_valid) sb.check_result(res);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		vtx_in_t v;
		sb = new();
		for (int i = 0; i < 3; i++) begin
			box_lo[i] = 0;
			box_hi[i] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset box is empty: positions all give zero
		v = '0;
		v.pos_x = 32'h7fff_ffff;
		v.norm_x = 16'h8000;
		v.tex_u = 32'h0001_0000;
		v.tex_v = 32'hffff_ffff;
		send_vertex(v);
		drain();

		// directed: unit box, threshold edges, out-of-box positions
		set_box(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'd7, 32'd6);
		v = '0;
		send_vertex(v);
		v.pos_x = 32'h0000_8000; v.pos_y = 32'd3; v.pos_z = 32'd3;
		v.norm_x = 16'h4000; v.norm_y = 16'h4000; v.norm_z = 16'h4000;
		v.tex_u = 32'h0000_8000; v.tex_v = 32'h0001_0001;
		send_vertex(v);
		v.pos_x = 32'h0001_0000; v.pos_y = 32'd7; v.pos_z = 32'h8000_0000;
		v.norm_x = 16'h7fff; v.norm_y = 16'h8000; v.norm_z = 16'h8000;
		v.tex_u = 32'h8000_0000; v.tex_v = 32'h7fff_ffff;
		send_vertex(v);
		v.pos_x = 32'hffff_ffff; v.pos_y = 32'd6; v.pos_z = 32'h7fff_ffff;
		v.norm_x = 16'h0000; v.norm_y = 16'h0001; v.norm_z = 16'h0000;
		v.tex_u = 32'hffff; v.tex_v = 32'd1;
		send_vertex(v);
		v.norm_x = 16'hffff; v.norm_y = 16'h0000; v.norm_z = 16'h7fff;
		send_vertex(v);
		drain();

		// full range box and an inverted one
		set_box(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		v.pos_x = 32'h8000_0000; v.pos_y = 32'h7fff_fffe; v.pos_z = 32'h0;
		send_vertex(v);
		v.pos_x = 32'h0; v.pos_y = 32'h7fff_ffff;
		send_vertex(v);
		drain();

		// random phases with changing boxes
		for (int ph = 0; ph < 8; ph++) begin
			logic [31:0] a[3], b[3];
			for (int i = 0; i < 3; i++) begin
				a[i] = $urandom();
				case ($urandom_range(3))
					0: b[i] = a[i] + $urandom_range(12);
					1: b[i] = $urandom();
					default: b[i] = a[i] + ($urandom() >> $urandom_range(1, 16));
				endcase
			end
			set_box(a[0], a[1], a[2], b[0], b[1], b[2]);
			calm = (ph == 3);
			repeat (250) send_vertex(random_vertex());
			drain();
		end
		calm = 0;

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
